// ===== rtl/core/igmp_hm_pkg.sv =====
package igmp_hm_pkg;

  // Event codes carried on the input tuser.
  localparam logic [2:0] OP_JOIN   = 3'd0;
  localparam logic [2:0] OP_LEAVE  = 3'd1;
  localparam logic [2:0] OP_TICK   = 3'd2;
  localparam logic [2:0] OP_REPORT = 3'd3;
  localparam logic [2:0] OP_QUERY  = 3'd4;

  // Membership states.
  localparam logic [1:0] ST_NONMEMBER = 2'd0;
  localparam logic [1:0] ST_DELAYING  = 2'd1;
  localparam logic [1:0] ST_IDLE      = 2'd2;

  // Message kinds carried on the output tuser.
  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_REPORT = 2'd1;
  localparam logic [1:0] KIND_LEAVE  = 2'd2;

  // IGMP type bytes.
  localparam logic [7:0] TYPE_REPORT = 8'h16;
  localparam logic [7:0] TYPE_LEAVE  = 8'h17;

  // Configuration register indexes.
  localparam logic [1:0] CFG_UNSOL_TICKS = 2'd0;
  localparam logic [1:0] CFG_DEF_RESP    = 2'd1;
  localparam logic [1:0] CFG_ROUTERS     = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] UNSOL_TICKS_RST = 16'd100;
  localparam logic [7:0]  DEF_RESP_RST    = 8'd100;
  localparam logic [31:0] ROUTERS_RST     = 32'hE000_0002;

  // Event queue between the front and back parts.
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Stream widths.
  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 3;
  localparam int M_DATA_W = 96;
  localparam int M_USER_W = 2;

  typedef struct packed {
    logic [15:0] unsol_ticks;
    logic [7:0]  def_resp;
    logic [31:0] routers;
  } igmp_hm_cfg_t;

  // A classified event as it waits in the queue.
  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] group;
    logic        group_zero;
    logic [15:0] delay;
  } igmp_hm_item_t;

  // Ones' complement checksum of type byte, zero byte and group address.
  function automatic logic [15:0] msg_checksum(input logic [7:0] typ,
                                               input logic [31:0] grp);
    logic [17:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;
    sum   = {2'b00, typ, 8'h00} + {2'b00, grp[31:16]} + {2'b00, grp[15:0]};
    fold1 = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
    fold2 = fold1[15:0] + {15'd0, fold1[16]};
    return ~fold2;
  endfunction

endpackage

// ===== rtl/core/igmp_hm_front.sv =====
module igmp_hm_front
  import igmp_hm_pkg::*;
(
  input  igmp_hm_cfg_t        cfg,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                push,
  output igmp_hm_item_t       push_item,
  input  logic                full
);

  logic [31:0] grp;
  logic [7:0]  mrt;

  assign grp = s_tdata[31:0];
  assign mrt = s_tdata[39:32];

  // Accept whenever the queue has room.
  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  // Classify the event and resolve the timer load it would use.
  always_comb begin
    push_item.op         = s_tuser;
    push_item.group      = grp;
    push_item.group_zero = (grp == 32'd0);
    push_item.delay      = 16'd0;
    case (s_tuser)
      OP_JOIN:  push_item.delay = cfg.unsol_ticks;
      OP_QUERY: push_item.delay = (mrt == 8'd0) ? {8'd0, cfg.def_resp} : {8'd0, mrt};
      default:  push_item.delay = 16'd0;
    endcase
  end

endmodule

// ===== rtl/core/igmp_hm_queue.sv =====
module igmp_hm_queue
  import igmp_hm_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  igmp_hm_item_t push_item,
  output logic          full,
  input  logic          pop,
  output igmp_hm_item_t pop_item,
  output logic          empty
);

  igmp_hm_item_t     mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/igmp_hm_back.sv =====
module igmp_hm_back
  import igmp_hm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  igmp_hm_cfg_t        cfg,
  input  igmp_hm_item_t       item,
  input  logic                empty,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic [M_USER_W-1:0] m_tuser
);

  logic [1:0]  membership;
  logic [31:0] joined_group;
  logic [15:0] countdown;

  logic [1:0]  membership_next;
  logic [31:0] joined_group_next;
  logic [15:0] countdown_next;
  logic [1:0]  kind;
  logic [7:0]  typ;
  logic [31:0] mgrp;
  logic [31:0] dest;
  logic [15:0] sum;

  // Take an event whenever the output register is free or being drained.
  assign pop = !empty && (!m_tvalid || m_tready);

  // Apply one event to the group entry.
  always_comb begin
    membership_next   = membership;
    joined_group_next = joined_group;
    countdown_next    = countdown;
    kind              = KIND_NONE;
    typ               = 8'd0;
    mgrp              = 32'd0;
    dest              = 32'd0;
    unique case (item.op)
      OP_JOIN: begin
        if (membership == ST_NONMEMBER) begin
          joined_group_next = item.group;
          membership_next   = ST_DELAYING;
          countdown_next    = item.delay;
          kind              = KIND_REPORT;
          typ               = TYPE_REPORT;
          mgrp              = item.group;
          dest              = item.group;
        end
      end
      OP_LEAVE: begin
        if (membership == ST_DELAYING || membership == ST_IDLE) begin
          membership_next = ST_NONMEMBER;
          countdown_next  = 16'd0;
          kind            = KIND_LEAVE;
          typ             = TYPE_LEAVE;
          mgrp            = joined_group;
          dest            = cfg.routers;
        end
      end
      OP_TICK: begin
        if (countdown != 16'd0) begin
          countdown_next = countdown - 16'd1;
          // Timer runs out on this tick while a report is pending.
          if (countdown == 16'd1 && membership == ST_DELAYING) begin
            membership_next = ST_IDLE;
            kind            = KIND_REPORT;
            typ             = TYPE_REPORT;
            mgrp            = joined_group;
            dest            = joined_group;
          end
        end
      end
      OP_REPORT: begin
        if (membership == ST_DELAYING && item.group == joined_group) begin
          membership_next = ST_IDLE;
          countdown_next  = 16'd0;
        end
      end
      OP_QUERY: begin
        if (membership == ST_IDLE && (item.group == joined_group || item.group_zero)) begin
          membership_next = ST_DELAYING;
          countdown_next  = item.delay;
        end
      end
      default: begin
      end
    endcase
    sum = (kind == KIND_NONE) ? 16'd0 : msg_checksum(typ, mgrp);
  end

  // Entry state.
  always_ff @(posedge clk) begin
    if (rst) begin
      membership   <= ST_NONMEMBER;
      joined_group <= 32'd0;
      countdown    <= 16'd0;
    end else if (pop) begin
      membership   <= membership_next;
      joined_group <= joined_group_next;
      countdown    <= countdown_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {6'd0, membership_next, sum, dest, mgrp, typ};
      m_tuser <= kind;
    end
  end

endmodule

// ===== rtl/core/igmp_host_membership_fsm.sv =====
// An accepted input transfer is written into the event queue; the entry update
// then takes it from the queue and loads its result into the output register.
// Throughput: one event per cycle while the result output is not stalled.
// The two-entry event queue lets input transfers continue while a result waits.
// Reset (synchronous, active high) empties the queue and output register, sets the
// entry to non-member with the timer idle, and restores the register defaults.
module igmp_host_membership_fsm
  import igmp_hm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration write channel.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // Event input stream.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // event_group[31:0], max_resp_time[39:32]
  input  logic [S_USER_W-1:0] s_tuser,   // op[2:0]
  // Result output stream.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // msg_type[7:0], msg_group[39:8],
                                         // msg_dest[71:40], msg_sum[87:72],
                                         // member_state[89:88], zero[95:90]
  output logic [M_USER_W-1:0] m_tuser    // send_kind[1:0]
);

  igmp_hm_cfg_t  cfg;
  logic          push;
  igmp_hm_item_t push_item;
  logic          full;
  logic          pop;
  igmp_hm_item_t pop_item;
  logic          empty;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unsol_ticks <= UNSOL_TICKS_RST;
      cfg.def_resp    <= DEF_RESP_RST;
      cfg.routers     <= ROUTERS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UNSOL_TICKS: cfg.unsol_ticks <= cfg_data[15:0];
        CFG_DEF_RESP:    cfg.def_resp    <= cfg_data[7:0];
        CFG_ROUTERS:     cfg.routers     <= cfg_data;
        default:         cfg.routers     <= cfg.routers;
      endcase
    end
  end

  igmp_hm_front u_front (
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  igmp_hm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (empty)
  );

  igmp_hm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .item     (pop_item),
    .empty    (empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/core/igmp_hm_checker.sv =====
module igmp_hm_checker
  import igmp_hm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [M_USER_W-1:0] m_tuser
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // A result with no message carries zero message fields.
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_NONE |-> m_tdata[87:0] == 88'd0)
    else $error("silent result carries message fields");

  // A leave always ends in the non-member state with the leave type.
  a_leave: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_LEAVE |->
      m_tdata[89:88] == ST_NONMEMBER && m_tdata[7:0] == TYPE_LEAVE)
    else $error("leave result inconsistent");

  // A report goes to its own group and leaves the entry a member.
  a_report: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_REPORT |->
      m_tdata[7:0] == TYPE_REPORT && m_tdata[39:8] == m_tdata[71:40] &&
      m_tdata[89:88] != ST_NONMEMBER)
    else $error("report result inconsistent");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind igmp_host_membership_fsm igmp_hm_checker u_checker (.*);

// ===== tb/igmp_host_membership_fsm_test.sv =====
`timescale 1ns / 100ps

module igmp_host_membership_fsm_test;
  import igmp_hm_pkg::*;

  // Event codes the block has no meaning for.
  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 115;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 250;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] grp;
    logic [7:0]  mrt;
  } igmp_event_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  typ;
    logic [31:0] grp;
    logic [31:0] dest;
    logic [15:0] sum;
    logic [1:0]  state;
  } igmp_msg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_index = '0;
  logic [31:0]         cfg_data  = '0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata   = '0;  // event_group[31:0], max_resp_time[39:32]
  logic [S_USER_W-1:0] s_tuser   = '0;  // op[2:0]
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;         // msg_type, msg_group, msg_dest, msg_sum,
                                        // member_state, zero padding
  logic [M_USER_W-1:0] m_tuser;         // send_kind[1:0]

  igmp_host_membership_fsm dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #2 clk = ~clk;

  // Events waiting to be offered, and messages the entry should still emit.
  igmp_event_t pending_events[$];
  igmp_msg_t   expected_msgs[$];

  // Shadow of the group entry and of its registers.
  logic [1:0]  mem_state  = ST_NONMEMBER;
  logic [31:0] mem_group  = '0;
  logic [15:0] mem_timer  = '0;
  logic [15:0] cfg_unsol  = UNSOL_TICKS_RST;
  logic [7:0]  cfg_resp   = DEF_RESP_RST;
  logic [31:0] cfg_router = ROUTERS_RST;

  int events_queued   = 0;
  int events_accepted = 0;
  int results_checked = 0;
  int reports_sent    = 0;
  int leaves_sent     = 0;
  int reg_writes      = 0;
  int error_count     = 0;
  int cycle_count     = 0;

  igmp_event_t tx_item;
  int          tx_gap   = 0;
  bit          tx_burst = 1'b0;
  int          rx_wait  = 0;
  bit          rx_burst = 1'b0;
  igmp_msg_t   want_msg;

  logic hold_req   = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left  = 0;

  logic [31:0] recent_groups[2];
  logic [31:0] grp;
  logic [7:0]  mrt;
  logic [2:0]  op;
  int          roll;
  int          p;
  int          n;

  // Checksum of the eight-byte message: type byte, zero byte, group address.
  function automatic logic [15:0] header_checksum(input logic [7:0] typ,
                                                  input logic [31:0] group);
    logic [31:0] acc;
    acc = {16'd0, typ, 8'h00} + {16'd0, group[31:16]} + {16'd0, group[15:0]};
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
    return ~acc[15:0];
  endfunction

  // Apply one event to the shadow entry and record the message it produces.
  task automatic advance_membership(input igmp_event_t ev);
    igmp_msg_t r;
    r = '0;
    case (ev.op)
      OP_JOIN: begin
        if (mem_state == ST_NONMEMBER) begin
          mem_group = ev.grp;
          mem_state = ST_DELAYING;
          mem_timer = cfg_unsol;
          r.kind = KIND_REPORT;
          r.typ  = TYPE_REPORT;
          r.grp  = mem_group;
          r.dest = mem_group;
        end
      end
      OP_LEAVE: begin
        if (mem_state == ST_DELAYING || mem_state == ST_IDLE) begin
          r.kind = KIND_LEAVE;
          r.typ  = TYPE_LEAVE;
          r.grp  = mem_group;
          r.dest = cfg_router;
          mem_state = ST_NONMEMBER;
          mem_timer = '0;
        end
      end
      OP_TICK: begin
        if (mem_timer != 16'd0) begin
          mem_timer = mem_timer - 16'd1;
          if (mem_timer == 16'd0 && mem_state == ST_DELAYING) begin
            r.kind = KIND_REPORT;
            r.typ  = TYPE_REPORT;
            r.grp  = mem_group;
            r.dest = mem_group;
            mem_state = ST_IDLE;
          end
        end
      end
      OP_REPORT: begin
        if (mem_state == ST_DELAYING && ev.grp == mem_group) begin
          mem_state = ST_IDLE;
          mem_timer = '0;
        end
      end
      OP_QUERY: begin
        if (mem_state == ST_IDLE && (ev.grp == mem_group || ev.grp == 32'd0)) begin
          mem_timer = (ev.mrt == 8'd0) ? {8'd0, cfg_resp} : {8'd0, ev.mrt};
          mem_state = ST_DELAYING;
        end
      end
      default: ;
    endcase
    if (r.kind != KIND_NONE) r.sum = header_checksum(r.typ, r.grp);
    if (r.kind == KIND_REPORT) reports_sent++;
    if (r.kind == KIND_LEAVE) leaves_sent++;
    r.state = mem_state;
    expected_msgs.push_back(r);
  endtask

  task automatic log_mismatch(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("MISMATCH result %0d %s: got %h, expected %h",
               results_checked, what, got, want);
  endtask

  task automatic queue_event(input logic [2:0] e_op, input logic [31:0] e_grp,
                             input logic [7:0] e_mrt);
    igmp_event_t ev;
    ev.op  = e_op;
    ev.grp = e_grp;
    ev.mrt = e_mrt;
    pending_events.push_back(ev);
    events_queued++;
  endtask

  // Write one register; called at a clock edge, returns at a clock edge.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_UNSOL_TICKS: cfg_unsol  = val[15:0];
      CFG_DEF_RESP:    cfg_resp   = val[7:0];
      CFG_ROUTERS:     cfg_router = val;
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
  endtask

  // Wait until every queued event has produced its message, then let the
  // pipeline drain before touching the registers.
  task automatic settle_idle();
    while (!(events_accepted == events_queued && expected_msgs.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Event driver: offers queued events with random gaps between transfers.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        advance_membership(tx_item);
        events_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_events.size() > 0) begin
          tx_item = pending_events.pop_front();
          s_tdata  <= {tx_item.mrt, tx_item.grp};
          s_tuser  <= tx_item.op;
          s_tvalid <= 1'b1;
          if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random stalls, and each transfer checked field by field.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_msgs.size() == 0) begin
          log_mismatch("unexpected result", {30'd0, m_tuser}, 32'd0);
        end else begin
          want_msg = expected_msgs.pop_front();
          if (m_tuser != want_msg.kind)
            log_mismatch("send_kind", {30'd0, m_tuser}, {30'd0, want_msg.kind});
          if (m_tdata[7:0] != want_msg.typ)
            log_mismatch("msg_type", {24'd0, m_tdata[7:0]}, {24'd0, want_msg.typ});
          if (m_tdata[39:8] != want_msg.grp)
            log_mismatch("msg_group", m_tdata[39:8], want_msg.grp);
          if (m_tdata[71:40] != want_msg.dest)
            log_mismatch("msg_dest", m_tdata[71:40], want_msg.dest);
          if (m_tdata[87:72] != want_msg.sum)
            log_mismatch("msg_sum", {16'd0, m_tdata[87:72]}, {16'd0, want_msg.sum});
          if (m_tdata[89:88] != want_msg.state)
            log_mismatch("member_state", {30'd0, m_tdata[89:88]},
                         {30'd0, want_msg.state});
          if (m_tdata[95:90] != 6'd0)
            log_mismatch("padding", {26'd0, m_tdata[95:90]}, 32'd0);
        end
        results_checked++;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      m_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // One long receiver hold-off so the event queue fills and input stalls.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_left  <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    recent_groups[0] = $urandom();
    recent_groups[1] = $urandom();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through every state and transition with short timers.
    write_reg(CFG_UNSOL_TICKS, 32'd2);
    write_reg(CFG_DEF_RESP, 32'd3);
    write_reg(CFG_ROUTERS, 32'hFFFF_FFFF);
    queue_event(OP_TICK,   32'h0000_0000, 8'h00);  // idle timer, nothing happens
    queue_event(OP_LEAVE,  32'h0000_0000, 8'h00);  // leave as non-member
    queue_event(OP_REPORT, 32'hFFFF_FFFF, 8'hFF);  // report as non-member
    queue_event(OP_JOIN,   32'hFFFF_FFFF, 8'h00);
    queue_event(OP_JOIN,   32'h0000_0000, 8'h00);  // join while a member
    queue_event(OP_QUERY,  32'hFFFF_FFFF, 8'hFF);  // query while delaying
    queue_event(OP_REPORT, 32'h1234_5678, 8'h00);  // report for another group
    queue_event(OP_TICK,   32'h0000_0000, 8'h00);
    queue_event(OP_TICK,   32'h0000_0000, 8'h00);  // expiry sends the report
    queue_event(OP_TICK,   32'h0000_0000, 8'h00);
    queue_event(OP_QUERY,  32'h0000_0000, 8'h00);  // general query, default delay
    queue_event(OP_REPORT, 32'hFFFF_FFFF, 8'h00);  // someone else reported
    queue_event(OP_QUERY,  32'hFFFF_FFFF, 8'hFF);
    queue_event(OP_BAD_FIRST, 32'h0000_0000, 8'h00);
    queue_event(OP_BAD_LAST,  32'hFFFF_FFFF, 8'hFF);
    queue_event(OP_LEAVE,  32'h0000_0000, 8'h00);
    queue_event(OP_JOIN,   32'h0000_0000, 8'h00);  // group zero
    queue_event(OP_TICK,   32'h0000_0000, 8'h00);
    queue_event(OP_TICK,   32'h0000_0000, 8'h00);
    queue_event(OP_QUERY,  32'h0000_0001, 8'h01);  // query for another group
    queue_event(OP_QUERY,  32'h0000_0000, 8'h01);
    queue_event(OP_TICK,   32'hFFFF_FFFF, 8'hFF);
    queue_event(OP_LEAVE,  32'hFFFF_FFFF, 8'hFF);
    settle_idle();

    // Zero delays leave the entry delaying with the timer stopped.
    write_reg(CFG_UNSOL_TICKS, 32'd0);
    write_reg(CFG_DEF_RESP, 32'd0);
    write_reg(CFG_ROUTERS, 32'h0000_0000);
    queue_event(OP_JOIN,   32'hA5A5_A5A5, 8'h00);
    queue_event(OP_TICK,   32'h0000_0000, 8'h00);
    queue_event(OP_REPORT, 32'hA5A5_A5A5, 8'h00);
    queue_event(OP_QUERY,  32'h0000_0000, 8'h00);
    queue_event(OP_TICK,   32'h0000_0000, 8'h00);
    queue_event(OP_LEAVE,  32'h0000_0000, 8'h00);
    settle_idle();

    // Random phases, each under its own register setting.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_reg(CFG_UNSOL_TICKS, {16'd0, UNSOL_TICKS_RST});
          write_reg(CFG_DEF_RESP, {24'd0, DEF_RESP_RST});
          write_reg(CFG_ROUTERS, ROUTERS_RST);
        end
        1: begin
          write_reg(CFG_UNSOL_TICKS, 32'd65535);
          write_reg(CFG_DEF_RESP, 32'd255);
          write_reg(CFG_ROUTERS, 32'h0000_0000);
        end
        2: begin
          write_reg(CFG_UNSOL_TICKS, 32'd1);
          write_reg(CFG_DEF_RESP, 32'd1);
          write_reg(CFG_ROUTERS, 32'hFFFF_FFFF);
        end
        3: begin
          write_reg(CFG_UNSOL_TICKS, {16'($urandom()), 16'd0});
          write_reg(CFG_DEF_RESP, {24'($urandom()), 8'd0});
          write_reg(CFG_ROUTERS, $urandom());
        end
        default: begin
          write_reg(CFG_UNSOL_TICKS, {16'($urandom()), 16'($urandom_range(1, 6))});
          write_reg(CFG_DEF_RESP, {24'($urandom()), 8'($urandom_range(1, 6))});
          write_reg(CFG_ROUTERS, $urandom());
        end
      endcase

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // Most events name the joined group or the general group.
        roll = $urandom_range(0, 99);
        if (roll < 50) grp = recent_groups[0];
        else if (roll < 62) grp = recent_groups[1];
        else if (roll < 75) grp = '0;
        else if (roll < 80) grp = '1;
        else grp = $urandom();

        roll = $urandom_range(0, 99);
        if (roll < 55) mrt = 8'($urandom_range(0, 4));
        else if (roll < 70) mrt = '0;
        else if (roll < 80) mrt = '1;
        else mrt = 8'($urandom());

        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          op = OP_JOIN;
          if ($urandom_range(0, 9) < 7) grp = $urandom();
          recent_groups[1] = recent_groups[0];
          recent_groups[0] = grp;
        end else if (roll < 20) begin
          op = OP_LEAVE;
        end else if (roll < 58) begin
          op = OP_TICK;
        end else if (roll < 72) begin
          op = OP_REPORT;
        end else if (roll < 97) begin
          op = OP_QUERY;
        end else begin
          op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
        end
        queue_event(op, grp, mrt);
      end

      if (p == 5) begin
        @(posedge clk);
        hold_req <= 1'b1;
      end
      settle_idle();
    end

    $display("Checked %0d results from %0d events: %0d reports and %0d leaves expected.",
             results_checked, events_accepted, reports_sent, leaves_sent);
    $display("Used %0d register writes over %0d random phases plus directed cases.",
             reg_writes, PHASES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/igmp_hm_pkg.sv
rtl/core/igmp_hm_front.sv
rtl/core/igmp_hm_queue.sv
rtl/core/igmp_hm_back.sv
rtl/core/igmp_host_membership_fsm.sv
rtl/core/igmp_hm_checker.sv
tb/igmp_host_membership_fsm_test.sv
